// File: src/ock_pkg.sv
// Shared types, fixed-point formats and color-space coefficients for the OKLab gamut clip.
package ock_pkg;

	localparam int FIELD_W   = 18;
	localparam int T_FRAC    = 24;
	localparam int T_W       = T_FRAC + 1;
	localparam int COEF_FRAC = 20;
	localparam int COEF_W    = 24;
	localparam int X_W       = 20;
	localparam int CUBE_W    = 38;
	localparam int SUM_W     = 63;
	localparam int CUBE_LAT  = 4;
	localparam int DATA_W    = 56;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic [T_W-1:0]            tval_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [X_W-1:0]     xval_t;
	typedef logic signed [CUBE_W-1:0]  cube_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam tval_t ONE_T = tval_t'(1) << T_FRAC;
	localparam logic signed [63:0] CUBE_LIMIT = 64'sd137438953471;

	// item context carried along the search chain
	typedef struct packed {
		field_t     l;
		field_t     a;
		field_t     b;
		tval_t      t;
		tval_t      lo;
		tval_t      hi;
		tval_t      mid;
		logic [2:0] need;
		logic [2:0] to_one;
	} ctx_t;

	// inverse OKLab rows, a and b coefficients
	localparam coef_t INV_LAB [3][2] = '{
		'{coef_t'(415590),  coef_t'(226287)},
		'{coef_t'(-110689), coef_t'(-66956)},
		'{coef_t'(-93831),  coef_t'(-1354221)}
	};

	// LMS to linear RGB rows
	localparam coef_t LMS_RGB [3][3] = '{
		'{coef_t'(4274773),  coef_t'(-3468387), coef_t'(242190)},
		'{coef_t'(-1330054), coef_t'(2736529),  coef_t'(-357899)},
		'{coef_t'(-4400),    coef_t'(-737588),  coef_t'(1790564)}
	};

endpackage

// File: src/ock_cube.sv
// Four-stage pipeline from (L, a, b, t) to the three saturated LMS cubes.
module ock_cube #(
	parameter int FIELD_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  ock_pkg::field_t       l,
	input  ock_pkg::field_t       a,
	input  ock_pkg::field_t       b,
	input  ock_pkg::tval_t        t,
	output ock_pkg::cube_t        cube [3]
);

	localparam int PA_W  = ock_pkg::FIELD_W + ock_pkg::T_W + 1;
	localparam int ACC_W = 42;
	localparam int XX_W  = 2 * ock_pkg::X_W;
	localparam int SQ_W  = XX_W - FIELD_FRAC_BITS;
	localparam int PR_W  = SQ_W + ock_pkg::X_W;

	logic signed [PA_W-1:0]  pa, pb;
	ock_pkg::field_t         l_s1, as_s1, bs_s1;
	logic signed [ACC_W-1:0] acc [3];
	ock_pkg::xval_t          x_s2 [3];
	logic signed [XX_W-1:0]  xx [3];
	logic signed [SQ_W-1:0]  sq_s3 [3];
	ock_pkg::xval_t          x_s3 [3];
	logic signed [PR_W-1:0]  pr [3];
	logic signed [63:0]      cw [3];
	ock_pkg::cube_t          cu [3];
	ock_pkg::cube_t          cube_s4 [3];

	// stage 1: scale chroma by t
	always_comb begin
		pa = PA_W'(a) * PA_W'($signed({1'b0, t}));
		pb = PA_W'(b) * PA_W'($signed({1'b0, t}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1  <= l;
			as_s1 <= ock_pkg::field_t'(pa >>> ock_pkg::T_FRAC);
			bs_s1 <= ock_pkg::field_t'(pb >>> ock_pkg::T_FRAC);
		end
	end

	// stage 2: inverse OKLab rows
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = (ACC_W'(l_s1) <<< ock_pkg::COEF_FRAC)
				+ ACC_W'(ock_pkg::INV_LAB[k][0]) * ACC_W'(as_s1)
				+ ACC_W'(ock_pkg::INV_LAB[k][1]) * ACC_W'(bs_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				x_s2[k] <= ock_pkg::xval_t'(acc[k] >>> ock_pkg::COEF_FRAC);
			end
		end
	end

	// stage 3: square
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xx[k] = XX_W'(x_s2[k]) * XX_W'(x_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s3[k] <= SQ_W'(xx[k] >>> FIELD_FRAC_BITS);
				x_s3[k]  <= x_s2[k];
			end
		end
	end

	// stage 4: cube and saturate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pr[k] = PR_W'(sq_s3[k]) * PR_W'(x_s3[k]);
			cw[k] = 64'(pr[k]) >>> FIELD_FRAC_BITS;
			if (cw[k] > ock_pkg::CUBE_LIMIT) begin
				cu[k] = ock_pkg::cube_t'(ock_pkg::CUBE_LIMIT);
			end else if (cw[k] < -ock_pkg::CUBE_LIMIT) begin
				cu[k] = ock_pkg::cube_t'(-ock_pkg::CUBE_LIMIT);
			end else begin
				cu[k] = ock_pkg::cube_t'(cw[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cube_s4 <= cu;
		end
	end

	assign cube = cube_s4;

endmodule

// File: src/ock_mix.sv
// One registered LMS-to-RGB row: the exact channel sum for channel CH.
module ock_mix #(
	parameter int CH = 0
) (
	input  logic           clk,
	input  logic           en,
	input  ock_pkg::cube_t cube [3],
	output ock_pkg::sum_t  sum
);

	ock_pkg::sum_t acc;
	ock_pkg::sum_t sum_s1;

	always_comb begin
		acc = '0;
		for (int k = 0; k < 3; k++) begin
			acc = acc + ock_pkg::sum_t'(ock_pkg::LMS_RGB[CH][k]) * ock_pkg::sum_t'(cube[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= acc;
		end
	end

	assign sum = sum_s1;

endmodule

// File: src/ock_check.sv
// Range check of all three channels at full chroma; marks which channels need a search.
module ock_check #(
	parameter int FIELD_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  ock_pkg::field_t   l,
	input  ock_pkg::field_t   a,
	input  ock_pkg::field_t   b,
	output logic              vld_out,
	output ock_pkg::ctx_t     ctx_out
);

	localparam int DEPTH = ock_pkg::CUBE_LAT + 1;
	localparam ock_pkg::sum_t ONE_CH =
		ock_pkg::sum_t'(1) <<< (FIELD_FRAC_BITS + ock_pkg::COEF_FRAC);

	ock_pkg::ctx_t  ctx0;
	ock_pkg::ctx_t  ctx_s [DEPTH];
	logic           vld_s [DEPTH];
	ock_pkg::cube_t cube [3];
	ock_pkg::sum_t  sum [3];
	ock_pkg::ctx_t  ctx_nx;
	ock_pkg::ctx_t  ctx_s6;
	logic           vld_s6;

	always_comb begin
		ctx0        = '0;
		ctx0.l      = l;
		ctx0.a      = a;
		ctx0.b      = b;
		ctx0.t      = ock_pkg::ONE_T;
	end

	ock_cube #(.FIELD_FRAC_BITS(FIELD_FRAC_BITS)) u_cube (
		.clk  (clk),
		.en   (en),
		.l    (l),
		.a    (a),
		.b    (b),
		.t    (ock_pkg::ONE_T),
		.cube (cube)
	);

	for (genvar c = 0; c < 3; c++) begin : g_mix
		ock_mix #(.CH(c)) u_mix (
			.clk  (clk),
			.en   (en),
			.cube (cube),
			.sum  (sum[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vld_s6 <= vld_s[DEPTH-1];
		end
	end

	always_comb begin
		ctx_nx = ctx_s[DEPTH-1];
		for (int c = 0; c < 3; c++) begin
			ctx_nx.to_one[c] = sum[c] > ONE_CH;
			ctx_nx.need[c]   = (sum[c] > ONE_CH) || (sum[c] < ock_pkg::sum_t'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= ctx0;
			for (int i = 1; i < DEPTH; i++) begin
				ctx_s[i] <= ctx_s[i-1];
			end
			ctx_s6 <= ctx_nx;
		end
	end

	assign vld_out = vld_s6;
	assign ctx_out = ctx_s6;

endmodule

// File: src/ock_step.sv
// One bisection step of the chroma scale for channel CH, six pipeline stages deep.
module ock_step #(
	parameter int FIELD_FRAC_BITS = 16,
	parameter int CH              = 0,
	parameter bit FIRST           = 1'b0,
	parameter bit LAST            = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  ock_pkg::ctx_t ctx_in,
	output logic          vld_out,
	output ock_pkg::ctx_t ctx_out
);

	localparam int DEPTH = ock_pkg::CUBE_LAT + 1;
	localparam ock_pkg::sum_t ONE_CH =
		ock_pkg::sum_t'(1) <<< (FIELD_FRAC_BITS + ock_pkg::COEF_FRAC);

	ock_pkg::ctx_t  ctx0;
	logic [ock_pkg::T_W:0] mid_sum;
	ock_pkg::ctx_t  ctx_s [DEPTH];
	logic           vld_s [DEPTH];
	ock_pkg::cube_t cube [3];
	ock_pkg::sum_t  sum;
	logic           beyond;
	ock_pkg::ctx_t  ctx_nx;
	ock_pkg::ctx_t  ctx_s6;
	logic           vld_s6;

	// open the interval at the first step of a channel, then take the midpoint
	always_comb begin
		ctx0 = ctx_in;
		if (FIRST) begin
			ctx0.lo = '0;
			ctx0.hi = ctx_in.t;
		end
		mid_sum  = {1'b0, ctx0.lo} + {1'b0, ctx0.hi};
		ctx0.mid = mid_sum[ock_pkg::T_W:1];
	end

	ock_cube #(.FIELD_FRAC_BITS(FIELD_FRAC_BITS)) u_cube (
		.clk  (clk),
		.en   (en),
		.l    (ctx0.l),
		.a    (ctx0.a),
		.b    (ctx0.b),
		.t    (ctx0.mid),
		.cube (cube)
	);

	ock_mix #(.CH(CH)) u_mix (
		.clk  (clk),
		.en   (en),
		.cube (cube),
		.sum  (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vld_s6 <= vld_s[DEPTH-1];
		end
	end

	// shrink hi while still outside, else raise lo; close on the last step if the channel needs a search
	always_comb begin
		ctx_nx = ctx_s[DEPTH-1];
		beyond = ctx_nx.to_one[CH] ? (sum > ONE_CH) : (sum < ock_pkg::sum_t'(0));
		if (beyond) begin
			ctx_nx.hi = ctx_nx.mid;
		end else begin
			ctx_nx.lo = ctx_nx.mid;
		end
		if (LAST && ctx_nx.need[CH]) begin
			ctx_nx.t = ctx_nx.lo;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= ctx0;
			for (int i = 1; i < DEPTH; i++) begin
				ctx_s[i] <= ctx_s[i-1];
			end
			ctx_s6 <= ctx_nx;
		end
	end

	assign vld_out = vld_s6;
	assign ctx_out = ctx_s6;

endmodule

// File: src/oklab_chroma_gamut_clip.sv
// Top level of the OKLab chroma gamut clip: check, bisection chain and output rounding.
//
// Streams OKLab colors (L, a, b) and pulls each one into the linear-RGB gamut by scaling
// its chroma. One request enters per clock and one result leaves per clock; every
// request gives exactly one result. The result passes through the evaluation pipeline:
// each of the 3 * SEARCH_STEPS + 1 color-space evaluations (one range check, then
// one per bisection step for red, green and blue) is a six-stage unit of scale,
// matrix, square, cube, mix and compare, followed by the output register. Every
// evaluation is laid out in hardware, so the chain never iterates. All stages advance
// together; when the output request is not taken the whole pipeline holds, and s_tready
// falls until the result leaves. L passes through unchanged; a and b are multiplied by
// the final scale t, rounded to nearest and saturated. Colors already inside the gamut
// leave unchanged.
module oklab_chroma_gamut_clip #(
	parameter int SEARCH_STEPS    = 8,
	parameter int FIELD_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// lightness [17:0], a_axis [35:18], b_axis [53:36], zero [55:54]
	input  logic [ock_pkg::DATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_lightness [17:0], out_a_axis [35:18], out_b_axis [53:36], zero [55:54]
	output logic [ock_pkg::DATA_W-1:0]  m_tdata
);

	localparam int N_STEP = 3 * SEARCH_STEPS;
	localparam int PA_W   = ock_pkg::FIELD_W + ock_pkg::T_W + 1;
	localparam int FW     = ock_pkg::FIELD_W;

	logic          en;
	ock_pkg::ctx_t ctx_c [N_STEP+1];
	logic          vld_c [N_STEP+1];
	ock_pkg::ctx_t fin;
	logic          fin_vld;
	logic signed [PA_W-1:0] ra, rb;
	ock_pkg::field_t out_a, out_b;
	logic          m_tvalid_q;
	logic [ock_pkg::DATA_W-1:0] m_tdata_q;

	function automatic ock_pkg::field_t sat_field(input logic signed [PA_W-1:0] v);
		logic signed [PA_W-1:0] hi;
		logic signed [PA_W-1:0] lo;
		hi = PA_W'(ock_pkg::field_t'({1'b0, {(FW-1){1'b1}}}));
		lo = PA_W'(ock_pkg::field_t'({1'b1, {(FW-1){1'b0}}}));
		if (v > hi) begin
			return ock_pkg::field_t'(hi);
		end else if (v < lo) begin
			return ock_pkg::field_t'(lo);
		end
		return ock_pkg::field_t'(v);
	endfunction

	// advance the whole pipeline unless a result is waiting
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	ock_check #(.FIELD_FRAC_BITS(FIELD_FRAC_BITS)) u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (s_tvalid),
		.l       (s_tdata[FW-1:0]),
		.a       (s_tdata[2*FW-1:FW]),
		.b       (s_tdata[3*FW-1:2*FW]),
		.vld_out (vld_c[0]),
		.ctx_out (ctx_c[0])
	);

	// red steps, then green, then blue
	for (genvar j = 0; j < N_STEP; j++) begin : g_step
		ock_step #(
			.FIELD_FRAC_BITS (FIELD_FRAC_BITS),
			.CH              (j / SEARCH_STEPS),
			.FIRST           ((j % SEARCH_STEPS) == 0),
			.LAST            ((j % SEARCH_STEPS) == (SEARCH_STEPS - 1))
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld_c[j]),
			.ctx_in  (ctx_c[j]),
			.vld_out (vld_c[j+1]),
			.ctx_out (ctx_c[j+1])
		);
	end

	assign fin     = ctx_c[N_STEP];
	assign fin_vld = vld_c[N_STEP];

	// round a and b times t to nearest, ties up
	always_comb begin
		ra = PA_W'(fin.a) * PA_W'($signed({1'b0, fin.t}))
			+ (PA_W'(1) <<< (ock_pkg::T_FRAC - 1));
		rb = PA_W'(fin.b) * PA_W'($signed({1'b0, fin.t}))
			+ (PA_W'(1) <<< (ock_pkg::T_FRAC - 1));
		out_a = sat_field(ra >>> ock_pkg::T_FRAC);
		out_b = sat_field(rb >>> ock_pkg::T_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= fin_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= {{(ock_pkg::DATA_W - 3*FW){1'b0}}, out_b, out_a, fin.l};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a finished item reaches the output register on the next advance
	a_fin_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && fin_vld |=> m_tvalid)
		else $error("finished item did not reach the output");

	// the search never widens the scale beyond one
	a_t_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_vld |-> fin.t <= ock_pkg::ONE_T)
		else $error("chroma scale above one");

	// a color inside the gamut keeps full chroma
	a_inside_keep: assert property (@(posedge clk) disable iff (!arst_n)
		fin_vld && (fin.need == 3'b000) |-> fin.t == ock_pkg::ONE_T)
		else $error("in-gamut color was scaled");

	// and its a component leaves unchanged
	a_inside_pass: assert property (@(posedge clk) disable iff (!arst_n)
		en && fin_vld && (fin.need == 3'b000) |=> m_tdata[2*FW-1:FW] == $past(fin.a))
		else $error("in-gamut a component changed");

endmodule
